// ===== rtl/lhbb_pkg.sv =====
// package with shared types and constants of the line hash bucket builder
`timescale 1ns / 1ps

package lhbb_pkg;

   // sizes
   localparam int MAX_LINES   = 4096;
   localparam int IDX_BITS    = $clog2(MAX_LINES);
   localparam int LENGTH_BITS = 13;
   localparam int WORD_BITS   = 32;
   localparam int COUNT_BITS  = 13;
   localparam int DIV_STEPS   = WORD_BITS;
   localparam int STEP_BITS   = $clog2(DIV_STEPS);

   typedef logic [7:0]             byte_type;
   typedef logic [WORD_BITS-1:0]   word_type;
   typedef logic [LENGTH_BITS-1:0] len_type;
   typedef logic [LENGTH_BITS:0]   len_count_type;
   typedef logic [IDX_BITS-1:0]    idx_type;
   typedef logic [IDX_BITS:0]      link_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [STEP_BITS-1:0]   step_type;

   localparam byte_type  NEWLINE_BYTE = 8'd10;
   localparam len_type   LEN_LIMIT    = {LENGTH_BITS{1'b1}};
   localparam count_type NB_MAX       = COUNT_BITS'(MAX_LINES);
   localparam count_type NB_MIN       = COUNT_BITS'(1);

   // control of the bucket store
   typedef struct packed {
      logic     rd_en;
      logic     wr_en;
      logic     clr_en;
      idx_type  addr;
      link_type head;
   } store_ctrl_type;

   // status of the modulo unit
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/lhbb_req_if.sv =====
// input channel interface: one text byte or end-of-text mark per transfer
`timescale 1ns / 1ps

interface lhbb_req_if;
   logic               valid;
   logic               ready;
   lhbb_pkg::byte_type text_byte;
   logic               end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== rtl/lhbb_rsp_if.sv =====
// result channel interface: one line record per transfer
`timescale 1ns / 1ps

interface lhbb_rsp_if;
   logic                valid;
   logic                ready;
   lhbb_pkg::idx_type   line_number;
   lhbb_pkg::word_type  hash_word;
   lhbb_pkg::len_type   line_len;
   lhbb_pkg::idx_type   bucket;
   lhbb_pkg::link_type  next_link;
   logic                too_long;
   logic                final_line;

   modport source (output valid, output line_number, output hash_word, output line_len,
                   output bucket, output next_link, output too_long, output final_line,
                   input ready);
   modport sink   (input valid, input line_number, input hash_word, input line_len,
                   input bucket, input next_link, input too_long, input final_line,
                   output ready);
endinterface

// ===== rtl/lhbb_mod_unit.sv =====
// iterative restoring modulo unit, one quotient bit per cycle
`timescale 1ns / 1ps

module lhbb_mod_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  lhbb_pkg::word_type       dividend,
   input  lhbb_pkg::count_type      divisor,
   output lhbb_pkg::div_status_type status,
   output lhbb_pkg::idx_type        remainder
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   lhbb_pkg::step_type  step_ff, step_in;
   lhbb_pkg::idx_type   rem_ff;
   lhbb_pkg::word_type  dvd_ff;
   lhbb_pkg::count_type dsr_ff;

   lhbb_pkg::count_type partial;
   lhbb_pkg::count_type diff;
   logic                fits;
   lhbb_pkg::idx_type   rem_in;

   // shift in the next dividend bit, subtract where it fits
   assign partial = {rem_ff, dvd_ff[lhbb_pkg::WORD_BITS-1]};
   assign fits    = (partial >= dsr_ff);
   assign diff    = partial - dsr_ff;
   assign rem_in  = fits ? diff[lhbb_pkg::IDX_BITS-1:0] : partial[lhbb_pkg::IDX_BITS-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == lhbb_pkg::STEP_BITS'(lhbb_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[lhbb_pkg::WORD_BITS-2:0], 1'b0};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

// ===== rtl/lhbb_bucket_store.sv =====
// bucket store: chain heads and per-bucket valid flags in memories
`timescale 1ns / 1ps

module lhbb_bucket_store (
   input  logic                     clock,
   input  lhbb_pkg::store_ctrl_type ctrl,
   output logic                     rd_valid,
   output lhbb_pkg::link_type       rd_head
);

   logic               valid_mem [lhbb_pkg::MAX_LINES];
   lhbb_pkg::link_type head_mem  [lhbb_pkg::MAX_LINES];

   logic               rd_valid_ff;
   lhbb_pkg::link_type rd_head_ff;

   // valid flags: cleared by the sweep, set on insert
   always_ff @(posedge clock) begin
      if (ctrl.clr_en) begin
         valid_mem[ctrl.addr] <= 1'b0;
      end else if (ctrl.wr_en) begin
         valid_mem[ctrl.addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
         rd_valid_ff <= valid_mem[ctrl.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         head_mem[ctrl.addr] <= ctrl.head;
      end
      if (ctrl.rd_en) begin
         rd_head_ff <= head_mem[ctrl.addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_head  = rd_head_ff;

endmodule

// ===== rtl/line_hash_bucket_builder.sv =====
// top level of the line hash bucket builder
//
//   port group   direction  transfer / write          payload
//   req          in         valid & ready             text_byte, end_of_text
//   rsp          out        valid & ready             line record (7 fields)
//   csr          in         csr_write_enable high     bucket_count (13 bits)
//
// a plain text byte is taken in the idle state; a line close runs the
// modulo unit (32 steps, one quotient bit each), then the store read and link
// a line closed while the error flag is set skips the modulo and the store read
// after reset and after every end of text the valid flags are swept, one bucket
// a cycle over all 4096 buckets, while req.ready is low (csr writes still land)
// the result sits in an output register; new bytes are taken while it waits,
// and only a further line close stalls until that record is transferred
`timescale 1ns / 1ps

module line_hash_bucket_builder (
   input  logic                clock,
   input  logic                reset,
   lhbb_req_if.sink            req,
   lhbb_rsp_if.source          rsp,
   input  logic                csr_write_enable,
   input  lhbb_pkg::count_type csr_write_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_LINK  = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;

   logic [2:0]              state_ff, state_in;

   // per-line running state
   lhbb_pkg::word_type      hash_ff, hash_in;
   lhbb_pkg::len_count_type len_ff, len_in;
   lhbb_pkg::idx_type       line_ff, line_in;
   logic                    err_ff, err_in;
   lhbb_pkg::count_type     bcount_ff;
   lhbb_pkg::idx_type       clr_cnt_ff, clr_cnt_in;

   // record of the line being closed
   lhbb_pkg::word_type      word_ff;
   lhbb_pkg::len_type       llen_ff;
   lhbb_pkg::idx_type       idx_ff;
   logic                    rerr_ff;
   logic                    final_ff;
   lhbb_pkg::idx_type       bucket_ff;

   // output register
   logic                    out_valid_ff, out_valid_in;
   lhbb_pkg::idx_type       out_line_ff;
   lhbb_pkg::word_type      out_word_ff;
   lhbb_pkg::len_type       out_len_ff;
   lhbb_pkg::idx_type       out_bucket_ff;
   lhbb_pkg::link_type      out_link_ff;
   logic                    out_err_ff;
   logic                    out_final_ff;

   logic                    accept;
   logic                    is_close;
   logic                    out_free;
   logic                    load_out;
   logic                    div_start;
   lhbb_pkg::len_type       len_sat;
   lhbb_pkg::word_type      word_now;
   lhbb_pkg::count_type     nb_eff;
   lhbb_pkg::link_type      link_val;

   lhbb_pkg::store_ctrl_type store_ctrl;
   logic                     rd_valid;
   lhbb_pkg::link_type       rd_head;
   lhbb_pkg::div_status_type div_stat;
   lhbb_pkg::idx_type        div_rem;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign is_close  = req.end_of_text || (req.text_byte == lhbb_pkg::NEWLINE_BYTE);
   assign out_free  = !out_valid_ff || rsp.ready;

   // record word from the running state: saturated length in the low bits
   assign len_sat  = (len_ff > lhbb_pkg::len_count_type'(lhbb_pkg::LEN_LIMIT)) ?
                     lhbb_pkg::LEN_LIMIT : len_ff[lhbb_pkg::LENGTH_BITS-1:0];
   assign word_now = lhbb_pkg::WORD_BITS'({hash_ff, len_sat});

   // bucket count clamped to one .. max lines
   always_comb begin
      if (bcount_ff == '0) begin
         nb_eff = lhbb_pkg::NB_MIN;
      end else if (bcount_ff > lhbb_pkg::NB_MAX) begin
         nb_eff = lhbb_pkg::NB_MAX;
      end else begin
         nb_eff = bcount_ff;
      end
   end

   // no modulo for lines closed under a set error flag
   assign div_start = accept && is_close && !err_ff;

   assign link_val = (rerr_ff || !rd_valid) ? '0 : rd_head;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      hash_in         = hash_ff;
      len_in          = len_ff;
      line_in         = line_ff;
      err_in          = err_ff;
      clr_cnt_in      = clr_cnt_ff;
      out_valid_in    = out_valid_ff && !rsp.ready;
      load_out        = 1'b0;
      store_ctrl.rd_en  = 1'b0;
      store_ctrl.wr_en  = 1'b0;
      store_ctrl.clr_en = 1'b0;
      store_ctrl.addr   = bucket_ff;
      store_ctrl.head   = lhbb_pkg::link_type'(idx_ff) + lhbb_pkg::link_type'(1);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_close) begin
                  hash_in = '0;
                  len_in  = '0;
                  if (req.end_of_text) begin
                     // text over: counters and error flag start afresh
                     line_in = '0;
                     err_in  = 1'b0;
                  end else begin
                     line_in = line_ff + 1'b1;
                  end
                  state_in = err_ff ? ST_LINK : ST_DIV;
               end else begin
                  hash_in = hash_ff ^ (hash_ff << 2) ^ lhbb_pkg::WORD_BITS'(req.text_byte);
                  if (len_ff <= lhbb_pkg::len_count_type'(lhbb_pkg::LEN_LIMIT)) begin
                     len_in = len_ff + 1'b1;
                  end
                  // length about to pass the limit
                  if (len_ff >= lhbb_pkg::len_count_type'(lhbb_pkg::LEN_LIMIT)) begin
                     err_in = 1'b1;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            store_ctrl.rd_en = 1'b1;
            state_in         = ST_LINK;
         end
         ST_LINK: begin
            // wait for the output register to free up
            if (out_free) begin
               load_out         = 1'b1;
               out_valid_in     = 1'b1;
               store_ctrl.wr_en = !rerr_ff;
               clr_cnt_in       = '0;
               state_in         = final_ff ? ST_CLEAR : ST_IDLE;
            end
         end
         ST_CLEAR: begin
            store_ctrl.clr_en = 1'b1;
            store_ctrl.addr   = clr_cnt_ff;
            clr_cnt_in        = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         hash_ff      <= '0;
         len_ff       <= '0;
         line_ff      <= '0;
         err_ff       <= 1'b0;
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
         bcount_ff    <= lhbb_pkg::NB_MIN;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         len_ff       <= len_in;
         line_ff      <= line_in;
         err_ff       <= err_in;
         clr_cnt_ff   <= clr_cnt_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            bcount_ff <= csr_write_data;
         end
      end
   end

   // line record captured at the closing transfer
   always_ff @(posedge clock) begin
      if (accept && is_close) begin
         word_ff  <= word_now;
         llen_ff  <= len_sat;
         idx_ff   <= line_ff;
         rerr_ff  <= err_ff;
         final_ff <= req.end_of_text;
         if (err_ff) begin
            bucket_ff <= '0;
         end
      end else if (div_stat.done) begin
         bucket_ff <= div_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_line_ff   <= idx_ff;
         out_word_ff   <= word_ff;
         out_len_ff    <= llen_ff;
         out_bucket_ff <= bucket_ff;
         out_link_ff   <= link_val;
         out_err_ff    <= rerr_ff;
         out_final_ff  <= final_ff;
      end
   end

   lhbb_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (word_now),
      .divisor   (nb_eff),
      .status    (div_stat),
      .remainder (div_rem)
   );

   lhbb_bucket_store u_store (
      .clock    (clock),
      .ctrl     (store_ctrl),
      .rd_valid (rd_valid),
      .rd_head  (rd_head)
   );

   assign rsp.valid       = out_valid_ff;
   assign rsp.line_number = out_line_ff;
   assign rsp.hash_word   = out_word_ff;
   assign rsp.line_len    = out_len_ff;
   assign rsp.bucket      = out_bucket_ff;
   assign rsp.next_link   = out_link_ff;
   assign rsp.too_long    = out_err_ff;
   assign rsp.final_line  = out_final_ff;

`ifndef SYNTH
   // the modulo result only arrives while the sequencer waits for it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("modulo result outside the modulo state");

   // no insert or read may land during the clearing sweep
   a_no_wr_in_clear: assert property (@(posedge clock) disable iff (reset)
      store_ctrl.clr_en |-> !store_ctrl.wr_en && !store_ctrl.rd_en)
      else $error("store access during clearing sweep");

   // a record of an errored text carries neither bucket nor link
   a_err_record: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.too_long) |-> (rsp.bucket == '0 && rsp.next_link == '0))
      else $error("errored record with bucket or link");

   // a final record is always followed by the clearing sweep
   a_final_clear: assert property (@(posedge clock) disable iff (reset)
      (load_out && final_ff) |=> (state_ff == ST_CLEAR))
      else $error("final record without clearing sweep");
`endif

endmodule
